// File: hdl/ipv4dap_pkg.sv
// Package with the character codes, the part limits and the radix type of the dotted address parser.
`timescale 1ns / 1ps
`default_nettype none

package ipv4dap_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] CHAR_UP_X   = 8'h58;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_F   = 8'h66;
  localparam logic [7:0] CHAR_LO_X   = 8'h78;

  localparam logic [31:0] LIMIT_8    = 32'h0000_00ff;
  localparam logic [31:0] LIMIT_16   = 32'h0000_ffff;
  localparam logic [31:0] LIMIT_24   = 32'h00ff_ffff;

endpackage

`default_nettype wire

// File: hdl/ipv4_dotted_address_parser.sv
// Dotted IPv4 address parser: one character per beat, one result beat per string.
// A NUL beat is held in the input register, then its result beat is registered in the result register.
// Throughput: one character beat per cycle; the per-character shift-add and the part
// packing sit between the input register and the result register. A NUL beat stalls
// only while an earlier result beat is still held by the receiver's stall.
// Reset clears the parse state and both valid flags; the next string starts fresh.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_address_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      address_o,
  output logic             bad_o
);
  import ipv4dap_pkg::*;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ZERO  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  logic        in_valid_q;
  logic [7:0]  ch_q;

  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic [31:0] accum_q, accum_d;
  logic [7:0]  part_q [3];
  logic [7:0]  part_d [3];
  logic [1:0]  count_q, count_d;
  logic        failed_q, failed_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] address_q, address_d;
  logic        bad_q, bad_d;

  logic        out_free;
  logic        is_nul;
  logic        step;
  logic        in_accept;

  logic        is_dec_digit;
  logic        is_hex_lower;
  logic        is_hex_upper;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [35:0] accum_wide;
  logic [35:0] scaled;
  logic [35:0] next_val;
  logic        is_space;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_nul    = (ch_q == CHAR_NUL);
  // A NUL beat waits until the result register is free; other beats never wait.
  assign step      = in_valid_q && (!is_nul || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept = in_valid_i && !in_stall_o;

  assign is_dec_digit = (ch_q >= CHAR_ZERO) && (ch_q <= CHAR_NINE);
  assign is_hex_lower = (radix_q == RADIX_HEX) && (ch_q >= CHAR_LO_A) && (ch_q <= CHAR_LO_F);
  assign is_hex_upper = (radix_q == RADIX_HEX) && (ch_q >= CHAR_UP_A) && (ch_q <= CHAR_UP_F);
  assign is_digit     = is_dec_digit || is_hex_lower || is_hex_upper;
  // The low nibble of a hex letter is one for 'a', so adding nine gives its value.
  assign digit_val    = is_dec_digit ? ch_q[3:0] : 4'(ch_q[3:0] + 4'd9);
  assign is_space     = (ch_q == CHAR_SPACE) || ((ch_q >= CHAR_TAB) && (ch_q <= CHAR_CR));

  assign accum_wide = {4'b0, accum_q};

  always_comb begin
    case (radix_q)
      RADIX_OCT: scaled = accum_wide << 3;
      RADIX_HEX: scaled = accum_wide << 4;
      default:   scaled = (accum_wide << 3) + (accum_wide << 1);
    endcase
    next_val = scaled + {32'b0, digit_val};
  end

  always_comb begin
    phase_d  = phase_q;
    radix_d  = radix_q;
    accum_d  = accum_q;
    part_d   = part_q;
    count_d  = count_q;
    failed_d = failed_q;
    address_d = address_q;
    bad_d     = bad_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (step) begin
      if (is_nul) begin
        bad_d = failed_q;
        address_d = 32'b0;
        if (!failed_q) begin
          unique case (count_q)
            2'd0: address_d = accum_q;
            2'd1: begin
              if (accum_q > LIMIT_24) bad_d = 1'b1;
              else address_d = {part_q[0], accum_q[23:0]};
            end
            2'd2: begin
              if (accum_q > LIMIT_16) bad_d = 1'b1;
              else address_d = {part_q[0], part_q[1], accum_q[15:0]};
            end
            default: begin
              if (accum_q > LIMIT_8) bad_d = 1'b1;
              else address_d = {part_q[0], part_q[1], part_q[2], accum_q[7:0]};
            end
          endcase
        end
        out_valid_d = 1'b1;
        phase_d  = PH_START;
        radix_d  = RADIX_DEC;
        accum_d  = 32'b0;
        part_d   = '{default: 8'b0};
        count_d  = 2'd0;
        failed_d = 1'b0;
      end else if (!failed_q && phase_q != PH_SKIP) begin
        if (phase_q == PH_START && ch_q == CHAR_ZERO) begin
          radix_d = RADIX_OCT;
          phase_d = PH_ZERO;
        end else if (phase_q == PH_ZERO && (ch_q == CHAR_LO_X || ch_q == CHAR_UP_X)) begin
          radix_d = RADIX_HEX;
          phase_d = PH_DIGIT;
        end else if (is_digit) begin
          if (|next_val[35:32]) failed_d = 1'b1;
          else accum_d = next_val[31:0];
          phase_d = PH_DIGIT;
        end else if (ch_q == CHAR_DOT) begin
          if (count_q == 2'd3 || accum_q > LIMIT_8) begin
            failed_d = 1'b1;
          end else begin
            part_d[count_q] = accum_q[7:0];
            count_d = count_q + 2'd1;
            accum_d = 32'b0;
            radix_d = RADIX_DEC;
            phase_d = PH_START;
          end
        end else if (is_space) begin
          phase_d = PH_SKIP;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_START;
      radix_q     <= RADIX_DEC;
      accum_q     <= 32'b0;
      part_q      <= '{default: 8'b0};
      count_q     <= 2'd0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      phase_q     <= phase_d;
      radix_q     <= radix_d;
      accum_q     <= accum_d;
      part_q      <= part_d;
      count_q     <= count_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= ch_i;
    end
    address_q <= address_d;
    bad_q     <= bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign bad_o       = bad_q;

endmodule

`default_nettype wire
